// File: rtl/ofd_pkg.sv
// Shared constants, register index codes and the struct types of the
// occupancy frontier detector. No dependencies; every file but ofd_ram imports it.
`default_nettype none

package ofd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CELL_W      = 8;
    localparam int COORD_W     = 10;
    localparam int SIZE_W      = 11;
    localparam int LIMIT_W     = 7;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CELL_W-1:0] UNKNOWN_CODE = 8'hFF;

    localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
    localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
    localparam logic [LIMIT_W-1:0] FREE_LIMIT_RST  = 7'd40;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_LIMIT  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0]  grid_width;
        logic [SIZE_W-1:0]  grid_height;
        logic [LIMIT_W-1:0] free_limit;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               frontier;
        logic               grid_done;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/ofd_if.sv
// Valid/ready channel interfaces for grid cells in and decided cells out.
// Depends on ofd_pkg for the field widths.
`default_nettype none

interface ofd_cell_if;
    import ofd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] occupancy;
    logic                     flush;

    modport source (output valid, output occupancy, output flush, input ready);
    modport sink   (input valid, input occupancy, input flush, output ready);
endinterface

interface ofd_result_if;
    import ofd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               frontier;
    logic               grid_done;

    modport source (output valid, output cell_x, output cell_y, output frontier,
                    output grid_done, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input frontier,
                    input grid_done, output ready);
endinterface

`default_nettype wire

// File: rtl/ofd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written in the same cycle returns the new data.
`default_nettype none

module ofd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ofd_scan.sv
// Raster position tracking, row buffers and the 4-neighbour frontier decision.
// Depends on ofd_pkg and ofd_ram.
`default_nettype none

module ofd_scan #(
    parameter int MAX_WIDTH  = ofd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ofd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [ofd_pkg::CELL_W-1:0] occupancy,
    input  wire logic                       flush,
    input  wire ofd_pkg::cfg_t              cfg,
    output ofd_pkg::result_t                res
);
    import ofd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [XW-1:0]     x_reg, x_next;
    logic [YW-1:0]     y_reg, y_next;
    logic              flushing_reg, flushing_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic [CELL_W-1:0] head0_reg, head0_next;
    logic [CELL_W-1:0] left_reg, left_next;

    logic [XW:0]       eff_w, x_inc;
    logic [YW:0]       eff_h, y_inc;
    logic [YW-1:0]     y_dec;
    logic              last_col, last_row, y_nz, y_gt1;
    logic              step, is_free, has_up, hit;
    logic [CELL_W-1:0] nxt;

    logic              mid_we, up_we;
    logic [XW-1:0]     mid_raddr;
    logic [CELL_W-1:0] mid_rdata;
    logic [0:0]        up_wdata, up_rdata;

    // Out-of-range sizes are clamped: zero acts as one, oversize as the maximum.
    always_comb
    begin
        if (cfg.grid_width == '0)
            eff_w = (XW+1)'(1);
        else if (32'(cfg.grid_width) > 32'(MAX_WIDTH))
            eff_w = (XW+1)'(MAX_WIDTH);
        else
            eff_w = (XW+1)'(cfg.grid_width);

        if (cfg.grid_height == '0)
            eff_h = (YW+1)'(1);
        else if (32'(cfg.grid_height) > 32'(MAX_HEIGHT))
            eff_h = (YW+1)'(MAX_HEIGHT);
        else
            eff_h = (YW+1)'(cfg.grid_height);
    end

    assign x_inc    = {1'b0, x_reg} + (XW+1)'(1);
    assign y_inc    = {1'b0, y_reg} + (YW+1)'(1);
    assign y_dec    = y_reg - YW'(1);
    assign last_col = (x_inc >= eff_w);
    assign last_row = (y_inc >= eff_h);
    assign y_nz     = (y_reg != '0);
    assign y_gt1    = ({1'b0, y_reg} > (YW+1)'(1));

    // While the last row drains, every item counts as a flush item.
    assign step = accept && (flushing_reg || !flush);

    // The right neighbour was fetched one item ahead; the centre is held in cur_reg.
    assign nxt     = mid_rdata;
    assign is_free = !cur_reg[CELL_W-1] && (cur_reg[LIMIT_W-1:0] < cfg.free_limit);
    assign has_up  = flushing_reg ? y_nz : y_gt1;

    always_comb
    begin
        hit = 1'b0;
        if ((x_reg != '0) && (left_reg == UNKNOWN_CODE))
            hit = 1'b1;
        if ((x_inc < eff_w) && (nxt == UNKNOWN_CODE))
            hit = 1'b1;
        if (has_up && up_rdata[0])
            hit = 1'b1;
        if (!flushing_reg && (occupancy == UNKNOWN_CODE))
            hit = 1'b1;
    end

    assign res.emit      = step && (flushing_reg || y_nz);
    assign res.cell_x    = COORD_W'(x_reg);
    assign res.cell_y    = flushing_reg ? COORD_W'(y_reg) : COORD_W'(y_dec);
    assign res.frontier  = is_free && hit;
    assign res.grid_done = flushing_reg && last_col;

    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        flushing_next = flushing_reg;
        cur_next      = cur_reg;
        head0_next    = head0_reg;
        left_next     = left_reg;
        if (step)
        begin
            left_next = cur_reg;
            if (flushing_reg)
            begin
                if (last_col)
                begin
                    x_next        = '0;
                    y_next        = '0;
                    flushing_next = 1'b0;
                end
                else
                begin
                    x_next = x_inc[XW-1:0];
                end
            end
            else
            begin
                if (x_reg == '0)
                    head0_next = occupancy;
                if (last_col)
                begin
                    x_next = '0;
                    if (last_row)
                        flushing_next = 1'b1;
                    else
                        y_next = y_inc[YW-1:0];
                end
                else
                begin
                    x_next = x_inc[XW-1:0];
                end
            end
            // Column zero of the row comes from the head register, others from the RAM.
            if (x_next == '0)
                cur_next = head0_next;
            else
                cur_next = nxt;
        end
    end

    assign mid_we    = step && !flushing_reg;
    assign up_we     = step && !flushing_reg && y_nz;
    assign up_wdata  = 1'(cur_reg == UNKNOWN_CODE);
    assign mid_raddr = (x_next == XW'(MAX_WIDTH - 1)) ? '0 : x_next + XW'(1);

    ofd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_row (
        .clk   (clk),
        .we    (mid_we),
        .waddr (x_reg),
        .wdata (occupancy),
        .re    (step),
        .raddr (mid_raddr),
        .rdata (mid_rdata)
    );

    ofd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_upper_row (
        .clk   (clk),
        .we    (up_we),
        .waddr (x_reg),
        .wdata (up_wdata),
        .re    (step),
        .raddr (x_next),
        .rdata (up_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            flushing_reg <= 1'b0;
        end
        else
        begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            flushing_reg <= flushing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        head0_reg <= head0_next;
        left_reg  <= left_next;
    end

`ifndef SYNTHESIS
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.grid_done |=> (x_reg == '0) && (y_reg == '0) && !flushing_reg)
        else $error("grid did not restart after its final cell");

    a_last_cell_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        step && !flushing_reg && last_col && last_row |=> flushing_reg)
        else $error("last cell of the grid did not start the flush");

    a_no_write_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> !mid_we && !up_we)
        else $error("row buffer written while flushing");

    a_upper_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        up_we |-> res.emit)
        else $error("upper row written without a decided cell");
`endif

endmodule

`default_nettype wire

// File: rtl/occupancy_frontier_detector_unit.sv
// Occupancy frontier detector. Grid cells enter in raster order, one item per
// clock unless results back up; a cell is decided when the cell below it
// arrives, so row zero gives no results and, after the last cell, grid_width
// flush items drain the final row (flush items at any other time are dropped).
// Each decided cell gives one result item with its coordinates, the frontier
// flag and an end-of-grid mark in the cycle after its item is accepted. The
// sustained rate is one item per cycle without stalls: two row buffers with one
// write and one read port each (MAX_WIDTH x 8 bits of values and MAX_WIDTH x 1
// bit of unknown flags) are read one item ahead of use, and one output register
// holds a result while the next item is taken. The buffers need no clearing
// pass after reset. Configuration writes take effect on the next item.
`default_nettype none

module occupancy_frontier_detector_unit #(
    parameter int MAX_WIDTH  = ofd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ofd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ofd_cell_if.sink                             cells,
    ofd_result_if.source                         result,
    input  wire logic                            cfg_we,
    input  wire logic [ofd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ofd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ofd_pkg::*;

    logic [SIZE_W-1:0]  grid_width_reg, grid_width_next;
    logic [SIZE_W-1:0]  grid_height_reg, grid_height_next;
    logic [LIMIT_W-1:0] free_limit_reg, free_limit_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    cfg_t               cfg;
    result_t            res;
    logic               accept;

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        free_limit_next  = free_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_next  = cfg_data[SIZE_W-1:0];
                REG_GRID_HEIGHT: grid_height_next = cfg_data[SIZE_W-1:0];
                REG_FREE_LIMIT:  free_limit_next  = cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.grid_width  = grid_width_reg;
    assign cfg.grid_height = grid_height_reg;
    assign cfg.free_limit  = free_limit_reg;

    // The next item may enter whenever the output register is empty or draining.
    assign cells.ready = !out_valid_reg || result.ready;
    assign accept      = cells.valid && cells.ready;

    ofd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .occupancy  (cells.occupancy),
        .flush      (cells.flush),
        .cfg        (cfg),
        .res        (res)
    );

    assign out_valid_next = cells.ready ? res.emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            free_limit_reg  <= FREE_LIMIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            free_limit_reg  <= free_limit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            out_reg <= res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.cell_x    = out_reg.cell_x;
    assign result.cell_y    = out_reg.cell_y;
    assign result.frontier  = out_reg.frontier;
    assign result.grid_done = out_reg.grid_done;

endmodule

`default_nettype wire

// File: tb/occupancy_frontier_detector_unit_tb.sv
// Testbench for the occupancy frontier detector: a directed table of grid items,
// then random grids under three idling patterns, checked against a local model.
// Depends on ofd_pkg, the channel interfaces and the detector top level.
`timescale 1ns / 1ps

module occupancy_frontier_detector_unit_tb;
    import ofd_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int NUM_PLAN_ROWS = 33;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               frontier;
        logic               done;
    } decided_cell_t;

    typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        check_kind_t            check;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic [CELL_W-1:0]      value;
        logic                   flush;
        decided_cell_t          typed;
    } plan_row_t;

    // Directed grids: a 3x2 grid with the value extremes, a 1x1 grid written as
    // zero sizes with nothing free, and a 4x3 grid that is narrowed and cut short
    // between rows.
    plan_row_t directed_plan [NUM_PLAN_ROWS] = '{
        '{STEP_CFG,  CHK_NONE,  REG_GRID_WIDTH,  11'd3,    8'h00, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_HEIGHT, 11'd2,    8'h00, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_FREE_LIMIT,  11'd127,  8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h55, 1'b1, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'hFF, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h7E, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h80, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h7F, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'hFF, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'hAA, 1'b1, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h64, 1'b0, '0},
        '{STEP_ITEM, CHK_TYPED, REG_GRID_WIDTH,  11'd0,    8'h00, 1'b1,
          '{10'd2, 10'd1, 1'b0, 1'b1}},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h00, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_HEIGHT, 11'd0,    8'h00, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_FREE_LIMIT,  11'd0,    8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h05, 1'b0, '0},
        '{STEP_ITEM, CHK_TYPED, REG_GRID_WIDTH,  11'd0,    8'h00, 1'b1,
          '{10'd0, 10'd0, 1'b0, 1'b1}},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_WIDTH,  11'd4,    8'h00, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_HEIGHT, 11'd3,    8'h00, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_FREE_LIMIT,  11'h7B2,  8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h0A, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'hFF, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'h14, 1'b0, '0},
        '{STEP_ITEM, CHK_NONE,  REG_GRID_WIDTH,  11'd0,    8'hFF, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_WIDTH,  11'd2,    8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h1E, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h31, 1'b0, '0},
        '{STEP_CFG,  CHK_NONE,  REG_GRID_HEIGHT, 11'd2,    8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'hFF, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h00, 1'b0, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h00, 1'b1, '0},
        '{STEP_ITEM, CHK_MODEL, REG_GRID_WIDTH,  11'd0,    8'h00, 1'b1, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ofd_cell_if   cell_ch ();
    ofd_result_if result_ch ();

    occupancy_frontier_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cell_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the detector state and its registers.
    logic [CELL_W-1:0] held_row [MAX_W];
    bit                above_unknown [MAX_W];
    logic [CELL_W-1:0] left_value;
    int                next_col;
    int                next_row;
    bit                draining;
    int                width_reg;
    int                height_reg;
    int                limit_reg;

    decided_cell_t awaited_cells [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;
    int items_counted  = 0;
    int cells_checked  = 0;
    int grids_run      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int effective_size(input int v, input int max_v);
        if (v == 0)
            return 1;
        if (v > max_v)
            return max_v;
        return v;
    endfunction

    function automatic bit counts_free(input logic [CELL_W-1:0] raw);
        int v;
        v = $signed(raw);
        return (v >= 0) && (v < limit_reg);
    endfunction

    function automatic bit frontier_at(input int x, input int w, input bit has_up,
                                       input bit has_down, input logic [CELL_W-1:0] below);
        bit hit;
        hit = 1'b0;
        if (!counts_free(held_row[x]))
            return 1'b0;
        if (x > 0 && left_value == UNKNOWN_CODE)
            hit = 1'b1;
        if (x + 1 < w && x + 1 < MAX_W && held_row[x + 1] == UNKNOWN_CODE)
            hit = 1'b1;
        if (has_up && above_unknown[x])
            hit = 1'b1;
        if (has_down && below == UNKNOWN_CODE)
            hit = 1'b1;
        return hit;
    endfunction

    // Advances the local state by one accepted item and gives the cell it decides.
    task automatic predict_decision(input logic [CELL_W-1:0] raw, input logic fl,
                                    output bit made, output decided_cell_t decided);
        int w;
        int h;
        int x;
        int y;
        bit last;
        w = effective_size(width_reg, MAX_W);
        h = effective_size(height_reg, MAX_H);
        x = next_col % MAX_W;
        y = next_row;
        made = 1'b0;
        decided = '0;
        if (draining)
        begin
            last = (x + 1 >= w);
            made = 1'b1;
            decided.x = COORD_W'(x);
            decided.y = COORD_W'(y);
            decided.frontier = frontier_at(x, w, y > 0, 1'b0, '0);
            decided.done = last;
            left_value = held_row[x];
            if (last)
            begin
                draining = 1'b0;
                next_col = 0;
                next_row = 0;
            end
            else
                next_col = x + 1;
        end
        else if (!fl)
        begin
            if (y > 0)
            begin
                made = 1'b1;
                decided.x = COORD_W'(x);
                decided.y = COORD_W'(y - 1);
                decided.frontier = frontier_at(x, w, y > 1, 1'b1, raw);
                decided.done = 1'b0;
                above_unknown[x] = (held_row[x] == UNKNOWN_CODE);
            end
            left_value = held_row[x];
            held_row[x] = raw;
            if (x + 1 >= w)
            begin
                next_col = 0;
                left_value = '0;
                if (y + 1 >= h)
                    draining = 1'b1;
                else
                    next_row = y + 1;
            end
            else
                next_col = x + 1;
        end
    endtask

    task automatic send_item(input logic [CELL_W-1:0] raw, input logic fl,
                             input check_kind_t mode, input decided_cell_t typed);
        decided_cell_t predicted;
        bit made;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cell_ch.valid = 1'b0;
            @(negedge clk);
        end
        cell_ch.valid = 1'b1;
        cell_ch.occupancy = raw;
        cell_ch.flush = fl;
        do
            @(posedge clk);
        while (cell_ch.ready !== 1'b1);
        if (draining || !fl)
            items_counted++;
        predict_decision(raw, fl, made, predicted);
        if (mode == CHK_TYPED)
            awaited_cells.insert(awaited_cells.size(), typed);
        else if (mode == CHK_MODEL && made)
            awaited_cells.insert(awaited_cells.size(), predicted);
        @(negedge clk);
    endtask

    // Some items give no result, so the channel is left idle after the last awaited result.
    task automatic wait_idle();
        cell_ch.valid = 1'b0;
        while (awaited_cells.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_GRID_WIDTH:  width_reg = int'(data);
            REG_GRID_HEIGHT: height_reg = int'(data);
            REG_FREE_LIMIT:  limit_reg = int'(data[LIMIT_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic logic [CELL_W-1:0] rand_value();
        logic [CELL_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = UNKNOWN_CODE;
            3, 4, 5: v = CELL_W'($urandom_range(0, limit_reg));
            6:
            begin
                case ($urandom_range(0, 2))
                    0: v = 8'h80;
                    1: v = 8'h7F;
                    default: v = 8'h00;
                endcase
            end
            default: v = CELL_W'($urandom);
        endcase
        return v;
    endfunction

    // Sends one whole grid, with an occasional stray flush among the cells, then
    // drains the last row with flush items and some plain cells.
    task automatic run_grid();
        int cells;
        cells = effective_size(width_reg, MAX_W) * effective_size(height_reg, MAX_H);
        for (int i = 0; i < cells; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(rand_value(), 1'b1, CHK_MODEL, '0);
            send_item(rand_value(), 1'b0, CHK_MODEL, '0);
        end
        while (draining)
            send_item(rand_value(), $urandom_range(0, 4) != 0, CHK_MODEL, '0);
        grids_run++;
    endtask

    task automatic random_grids(input int send_pct, input int recv_pct, input int target);
        int start;
        int lim;
        int gw;
        int gh;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start = items_counted;
        while (items_counted - start < target)
        begin
            wait_idle();
            gw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            gh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            write_reg(REG_GRID_WIDTH, CFG_DATA_W'(gw));
            write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(gh));
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 5))
                    0: lim = 0;
                    1: lim = 127;
                    default: lim = $urandom_range(0, 127);
                endcase
                write_reg(REG_FREE_LIMIT, {4'($urandom_range(0, 15)), lim[LIMIT_W-1:0]});
            end
            cfg_we = 1'b0;
            repeat ($urandom_range(0, 2))
                send_item(rand_value(), 1'b1, CHK_MODEL, '0);
            run_grid();
        end
    endtask

    task automatic report_mismatch(input string why, input decided_cell_t want,
                                   input decided_cell_t got);
        if (mismatches < 10)
            $display("%0t: %s: want x=%0d y=%0d f=%0b d=%0b, got x=%0d y=%0d f=%0b d=%0b",
                     $time, why, want.x, want.y, want.frontier, want.done,
                     got.x, got.y, got.frontier, got.done);
        mismatches++;
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        decided_cell_t got;
        decided_cell_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && ((cell_ch.valid && cell_ch.ready)
                          || (result_ch.valid && result_ch.ready)))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got = '{result_ch.cell_x, result_ch.cell_y,
                        result_ch.frontier, result_ch.grid_done};
                if (awaited_cells.size() == 0)
                    report_mismatch("result with nothing awaited", '0, got);
                else
                begin
                    want = awaited_cells.pop_front();
                    cells_checked++;
                    if (got.x !== want.x || got.y !== want.y
                        || got.frontier !== want.frontier || got.done !== want.done)
                        report_mismatch("decided cell differs", want, got);
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        plan_row_t row;
        cell_ch.valid = 1'b0;
        cell_ch.occupancy = '0;
        cell_ch.flush = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        width_reg = GRID_WIDTH_RST;
        height_reg = GRID_HEIGHT_RST;
        limit_reg = FREE_LIMIT_RST;
        next_col = 0;
        next_row = 0;
        draining = 1'b0;
        left_value = '0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 27;
        recv_stall_pct = 60;
        for (int i = 0; i < NUM_PLAN_ROWS; i++)
        begin
            row = directed_plan[i];
            if (row.kind == STEP_CFG)
            begin
                if (i == 0 || directed_plan[i - 1].kind != STEP_CFG)
                    wait_idle();
                write_reg(row.index, row.data);
                if (i == NUM_PLAN_ROWS - 1 || directed_plan[i + 1].kind != STEP_CFG)
                    cfg_we = 1'b0;
            end
            else
                send_item(row.value, row.flush, row.check, row.typed);
        end

        random_grids(27, 60, 200);
        random_grids(60, 27, 200);
        random_grids(0, 0, 200);

        wait_idle();
        mismatches += awaited_cells.size();
        $display("Run covered %0d grid items in %0d grids of up to 12 by 6 cells,",
                 items_counted, grids_run);
        $display("with %0d decided cells checked and %0d mismatches.", cells_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
